// ===== design/c3sf_pkg.sv =====
// c3sf_pkg: shared types, widths, register indexes and reset values
// for the 3x3 streaming correlation filter. No dependencies.
package c3sf_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int KERNEL        = 3;
    localparam int PIX_W         = 8;
    localparam int COEF_W        = 7;
    localparam int COEFS_W       = 63;
    localparam int DIM_W         = 11;
    localparam int ROW_W         = 11;
    localparam int PROD_W        = 15;
    localparam int COL_SUM_W     = 17;
    localparam int GRAD_W        = 19;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 24;
    localparam int CFG_IDX_W     = 2;
    localparam int STORE_W       = 2 * PIX_W;

    localparam logic [COEFS_W-1:0] COEF_RESET = 63'd72616214928572543;
    localparam logic [DIM_W-1:0]   DIM_RESET  = 11'd1024;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_COEF   = 2'd0;
    localparam cfg_idx_t REG_WIDTH  = 2'd1;
    localparam cfg_idx_t REG_HEIGHT = 2'd2;

    typedef logic [PIX_W-1:0]  pix_t;

    // per-cycle controls for the window cells
    typedef struct packed {
        logic shift;  // take the neighbor's column
        logic calc;   // register the column sum
    } cell_ctrl_t;

endpackage

// ===== design/c3sf_line_store.sv =====
// c3sf_line_store: two line buffers in one memory word (upper in the low byte,
// middle in the high byte), registered read. Depends on c3sf_pkg.
module c3sf_line_store #(
    parameter int DEPTH = c3sf_pkg::MAX_WIDTH_DEF + 2,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                            clk,
    input  logic                            rd_en,
    input  logic [AW-1:0]                   rd_addr,
    output logic [c3sf_pkg::STORE_W-1:0]    rd_data,
    input  logic                            wr_en,
    input  logic [AW-1:0]                   wr_addr,
    input  logic [c3sf_pkg::STORE_W-1:0]    wr_data
);

    logic [c3sf_pkg::STORE_W-1:0] mem [DEPTH];
    logic [c3sf_pkg::STORE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/c3sf_cell.sv =====
// c3sf_cell: one window column (three pixels) and its weighted column sum.
// Cells form a chain; each takes the column of its right neighbor. Depends on c3sf_pkg.
module c3sf_cell (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  c3sf_pkg::cell_ctrl_t                              ctrl,
    input  logic [c3sf_pkg::KERNEL-1:0][c3sf_pkg::PIX_W-1:0]  col_in,
    input  logic [c3sf_pkg::KERNEL-1:0][c3sf_pkg::COEF_W-1:0] coef,
    output logic [c3sf_pkg::KERNEL-1:0][c3sf_pkg::PIX_W-1:0]  col_out,
    output logic signed [c3sf_pkg::COL_SUM_W-1:0]             psum
);

    logic [c3sf_pkg::KERNEL-1:0][c3sf_pkg::PIX_W-1:0] col_reg;
    logic signed [c3sf_pkg::COL_SUM_W-1:0]            psum_reg;
    logic signed [c3sf_pkg::COL_SUM_W-1:0]            psum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            col_reg <= col_in;
        end
    end

    always_comb
    begin
        logic signed [c3sf_pkg::PROD_W-1:0] prod;
        psum_next = '0;
        for (int y = 0; y < c3sf_pkg::KERNEL; y++)
        begin
            prod      = $signed(coef[y]) * $signed({1'b0, col_reg[y]});
            psum_next = psum_next + c3sf_pkg::COL_SUM_W'(prod);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.calc)
        begin
            psum_reg <= psum_next;
        end
    end

    assign col_out = col_reg;
    assign psum    = psum_reg;

endmodule

// ===== design/conv3x3_stream_filter_top.sv =====
// conv3x3_stream_filter_top: 3x3 correlation over a padded 8-bit pixel stream.
// Pipeline: line store read at the pixel beat, then window shift, column sums, final add.
// Throughput: one pixel per clock, set by the one read and one write port of the line
// store; an output beat left waiting stalls intake.
// Reset (async, active low): counters, window and pipeline valids clear, registers
// return to Sobel-x, 1024 x 1024; the line store is not cleared.
// Depends on c3sf_pkg, c3sf_line_store, c3sf_cell.
module conv3x3_stream_filter_top #(
    parameter int MAX_WIDTH = c3sf_pkg::MAX_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // pixel in: tdata[7:0] pixel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [c3sf_pkg::IN_TDATA_W-1:0]     s_tdata,
    // result out: tdata[18:0] gradient, zero fill above
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [c3sf_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast,  // row_end
    output logic                                m_tuser,  // [0] frame_end
    // register write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [c3sf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [c3sf_pkg::COEFS_W-1:0]        cfg_data
);

    localparam int DEPTH = MAX_WIDTH + 2;
    localparam int CW    = $clog2(DEPTH);
    localparam int CMPW  = (CW > c3sf_pkg::DIM_W) ? CW : c3sf_pkg::DIM_W;
    localparam int K     = c3sf_pkg::KERNEL;

    // ---------------- configuration ----------------
    logic [c3sf_pkg::COEFS_W-1:0] coef_reg;
    logic [c3sf_pkg::DIM_W-1:0]   width_reg;
    logic [c3sf_pkg::DIM_W-1:0]   height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg   <= c3sf_pkg::COEF_RESET;
            width_reg  <= c3sf_pkg::DIM_RESET;
            height_reg <= c3sf_pkg::DIM_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                c3sf_pkg::REG_COEF:   coef_reg   <= cfg_data;
                c3sf_pkg::REG_WIDTH:  width_reg  <= cfg_data[c3sf_pkg::DIM_W-1:0];
                c3sf_pkg::REG_HEIGHT: height_reg <= cfg_data[c3sf_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp dimensions, last padded column/row
    logic [CMPW-1:0]               width_ext;
    logic [CMPW-1:0]               width_eff;
    logic [CMPW-1:0]               last_col;
    logic [c3sf_pkg::ROW_W-1:0]    height_eff;
    logic [c3sf_pkg::ROW_W-1:0]    last_row;

    always_comb
    begin
        width_ext = CMPW'(width_reg);
        if (width_ext == '0)
            width_eff = CMPW'(1);
        else if (width_ext > CMPW'(MAX_WIDTH))
            width_eff = CMPW'(MAX_WIDTH);
        else
            width_eff = width_ext;
        last_col = width_eff + CMPW'(1);

        if (height_reg == '0)
            height_eff = c3sf_pkg::ROW_W'(1);
        else if (height_reg > c3sf_pkg::ROW_W'(c3sf_pkg::MAX_HEIGHT))
            height_eff = c3sf_pkg::ROW_W'(c3sf_pkg::MAX_HEIGHT);
        else
            height_eff = height_reg;
        last_row = height_eff + c3sf_pkg::ROW_W'(1);
    end

    // ---------------- intake and position counters ----------------
    logic adv;
    logic acc;
    logic m_valid_reg;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;
    assign acc      = s_tvalid && adv;

    logic [CW-1:0]              col_reg, col_next;
    logic [c3sf_pkg::ROW_W-1:0] row_reg, row_next;
    logic                       col_end, rows_done, emit;

    always_comb
    begin
        col_end   = CMPW'(col_reg) >= last_col;
        rows_done = row_reg >= last_row;
        emit      = (row_reg >= c3sf_pkg::ROW_W'(2)) && (col_reg >= CW'(2));
        col_next  = col_reg;
        row_next  = row_reg;
        if (acc)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = rows_done ? '0 : row_reg + c3sf_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- stage 1: line store read returns ----------------
    logic                 v1_reg;
    logic                 emit1_reg, re1_reg, fe1_reg;
    c3sf_pkg::pix_t       px1_reg;
    logic [CW-1:0]        c1_reg;
    logic [c3sf_pkg::STORE_W-1:0] store_rd;
    c3sf_pkg::pix_t       up_px, mid_px;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            px1_reg   <= s_tdata[c3sf_pkg::PIX_W-1:0];
            c1_reg    <= col_reg;
            emit1_reg <= emit;
            re1_reg   <= col_end;
            fe1_reg   <= col_end && rows_done;
        end
    end

    c3sf_line_store #(
        .DEPTH (DEPTH),
        .AW    (CW)
    ) u_store (
        .clk     (clk),
        .rd_en   (acc),
        .rd_addr (col_reg),
        .rd_data (store_rd),
        .wr_en   (adv && v1_reg),
        .wr_addr (c1_reg),
        .wr_data ({px1_reg, mid_px})
    );

    assign up_px  = store_rd[c3sf_pkg::PIX_W-1:0];
    assign mid_px = store_rd[c3sf_pkg::STORE_W-1:c3sf_pkg::PIX_W];

    // ---------------- window cells ----------------
    c3sf_pkg::cell_ctrl_t                               cell_ctrl;
    logic [K-1:0][K-1:0][c3sf_pkg::PIX_W-1:0]           cell_in;
    logic [K-1:0][K-1:0][c3sf_pkg::PIX_W-1:0]           cell_out;
    logic [K-1:0][K-1:0][c3sf_pkg::COEF_W-1:0]          cell_coef;
    logic signed [c3sf_pkg::COL_SUM_W-1:0]              psum [K];

    assign cell_ctrl.shift = adv && v1_reg;
    assign cell_ctrl.calc  = adv;

    for (genvar x = 0; x < K; x++)
    begin : g_cell
        if (x == K - 1)
        begin : g_head
            assign cell_in[x] = {px1_reg, mid_px, up_px};
        end
        else
        begin : g_link
            assign cell_in[x] = cell_out[x+1];
        end

        for (genvar y = 0; y < K; y++)
        begin : g_coef
            assign cell_coef[x][y] =
                coef_reg[c3sf_pkg::COEF_W*(y*K+x) +: c3sf_pkg::COEF_W];
        end

        c3sf_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (cell_ctrl),
            .col_in  (cell_in[x]),
            .coef    (cell_coef[x]),
            .col_out (cell_out[x]),
            .psum    (psum[x])
        );
    end

    // ---------------- stages 2, 3 and output ----------------
    logic v2_reg, re2_reg, fe2_reg;
    logic v3_reg, re3_reg, fe3_reg;
    logic signed [c3sf_pkg::GRAD_W-1:0] grad_reg;
    logic                               row_end_reg, frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg      <= v1_reg && emit1_reg;
            v3_reg      <= v2_reg;
            m_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            re2_reg       <= re1_reg;
            fe2_reg       <= fe1_reg;
            re3_reg       <= re2_reg;
            fe3_reg       <= fe2_reg;
            row_end_reg   <= re3_reg;
            frame_end_reg <= fe3_reg;
            grad_reg      <= c3sf_pkg::GRAD_W'(psum[0]) + c3sf_pkg::GRAD_W'(psum[1])
                           + c3sf_pkg::GRAD_W'(psum[2]);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = c3sf_pkg::OUT_TDATA_W'(unsigned'(grad_reg));
    assign m_tlast  = row_end_reg;
    assign m_tuser  = frame_end_reg;

endmodule

// ===== design/c3sf_checker.sv =====
// c3sf_checker: port-level assertions for conv3x3_stream_filter_top, attached by bind.
// Depends on c3sf_pkg.
module c3sf_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [c3sf_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tlast,
    input logic                             m_tuser
);

    // a frame always closes on the last beat of a row
    a_frame_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end without row end");

    // fill bits above the gradient stay zero
    a_tdata_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[c3sf_pkg::OUT_TDATA_W-1:c3sf_pkg::GRAD_W] == '0))
        else $error("gradient fill bits not zero");

    // intake stops while a result beat waits
    a_intake_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output stalled");

    // held result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result beat changed");

endmodule

bind conv3x3_stream_filter_top c3sf_checker u_c3sf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== test/conv3x3_stream_filter_top_check.sv =====
// conv3x3_stream_filter_top_check: watches the pixel, result and register channels of
// conv3x3_stream_filter_top, predicts every result beat and compares it field by field.
// Depends on c3sf_pkg.
`timescale 1ns / 1ps
module conv3x3_stream_filter_top_check
    import c3sf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   m_tlast,
    input  logic                   m_tuser,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [COEFS_W-1:0]     cfg_data,
    output int                     mismatches,
    output int                     pending,
    output int                     results_seen,
    output int                     frames_seen
);

    localparam int STORE_DEPTH = MAX_WIDTH_DEF + 2;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gradient;
        logic                     row_end;
        logic                     frame_end;
    } sobel_result_t;

    logic [COEFS_W-1:0] coefs;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    pix_t               upper_line [STORE_DEPTH];
    pix_t               middle_line [STORE_DEPTH];
    pix_t               win [KERNEL][KERNEL];
    int unsigned        col;
    int unsigned        row;
    sobel_result_t      gradient_q [$];
    int                 fail_count;
    int                 result_count;
    int                 frame_count;

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
        if (v == '0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // shift one pixel into the line stores and window; queue a gradient once
    // the window covers a full 3x3 block of the padded frame
    task automatic take_pixel(input pix_t px);
        int unsigned              last_col;
        int unsigned              last_row;
        logic                     col_end;
        logic                     rows_done;
        pix_t                     up;
        pix_t                     mid;
        int                       sum;
        logic signed [COEF_W-1:0] k;
        sobel_result_t            r;
        last_col  = clamp_dim(width_reg, MAX_WIDTH_DEF) + 1;
        last_row  = clamp_dim(height_reg, MAX_HEIGHT) + 1;
        col_end   = (col >= last_col);
        rows_done = (row >= last_row);
        up  = upper_line[col];
        mid = middle_line[col];
        upper_line[col]  = mid;
        middle_line[col] = px;
        for (int y = 0; y < KERNEL; y++)
            for (int x = 0; x < KERNEL - 1; x++)
                win[y][x] = win[y][x+1];
        win[0][KERNEL-1] = up;
        win[1][KERNEL-1] = mid;
        win[2][KERNEL-1] = px;
        if (row >= 2 && col >= 2)
        begin
            sum = 0;
            for (int y = 0; y < KERNEL; y++)
                for (int x = 0; x < KERNEL; x++)
                begin
                    k = coefs[COEF_W*(y*KERNEL+x) +: COEF_W];
                    sum += int'(k) * int'(win[y][x]);
                end
            r.gradient  = sum[GRAD_W-1:0];
            r.row_end   = col_end;
            r.frame_end = col_end && rows_done;
            gradient_q.push_back(r);
        end
        if (col_end)
        begin
            col = 0;
            row = rows_done ? 0 : row + 1;
        end
        else
            col = col + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        sobel_result_t want;
        if (!rst_n)
        begin
            coefs      = COEF_RESET;
            width_reg  = DIM_RESET;
            height_reg = DIM_RESET;
            col        = 0;
            row        = 0;
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                upper_line[i]  = '0;
                middle_line[i] = '0;
            end
            for (int y = 0; y < KERNEL; y++)
                for (int x = 0; x < KERNEL; x++)
                    win[y][x] = '0;
            gradient_q.delete();
            fail_count   = 0;
            result_count = 0;
            frame_count  = 0;
        end
        else
        begin
            // result side first: a beat can never belong to the pixel taken this edge
            if (m_tvalid && m_tready)
            begin
                result_count++;
                if (m_tuser)
                    frame_count++;
                if (gradient_q.size() == 0)
                begin
                    $error("result beat with nothing expected: gradient %0d",
                           $signed(m_tdata[GRAD_W-1:0]));
                    fail_count++;
                end
                else
                begin
                    want = gradient_q.pop_front();
                    if (m_tdata[GRAD_W-1:0] !== want.gradient)
                    begin
                        $error("gradient: expected %0d, got %0d", want.gradient,
                               $signed(m_tdata[GRAD_W-1:0]));
                        fail_count++;
                    end
                    if (m_tdata[OUT_TDATA_W-1:GRAD_W] !== '0)
                    begin
                        $error("tdata fill: expected 0, got %0h", m_tdata[OUT_TDATA_W-1:GRAD_W]);
                        fail_count++;
                    end
                    if (m_tlast !== want.row_end)
                    begin
                        $error("row_end: expected %0b, got %0b", want.row_end, m_tlast);
                        fail_count++;
                    end
                    if (m_tuser !== want.frame_end)
                    begin
                        $error("frame_end: expected %0b, got %0b", want.frame_end, m_tuser);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    REG_COEF:   coefs      = cfg_data;
                    REG_WIDTH:  width_reg  = cfg_data[DIM_W-1:0];
                    REG_HEIGHT: height_reg = cfg_data[DIM_W-1:0];
                    default:    ;
                endcase
            if (s_tvalid && s_tready)
                take_pixel(s_tdata[PIX_W-1:0]);
        end
        mismatches   <= fail_count;
        pending      <= gradient_q.size();
        results_seen <= result_count;
        frames_seen  <= frame_count;
    end

endmodule

// ===== test/conv3x3_stream_filter_top_test.sv =====
// conv3x3_stream_filter_top_test: drives padded frames and register writes into
// conv3x3_stream_filter_top with random idling on both sides and gives the verdict.
// Depends on c3sf_pkg, conv3x3_stream_filter_top and conv3x3_stream_filter_top_check.
`timescale 1ns / 1ps
module conv3x3_stream_filter_top_test;
    import c3sf_pkg::*;

    localparam int        HALF_PERIOD   = 6;
    localparam int        IDLE_PCT      = 35;
    localparam int        DRAIN_GAP     = 8;      // margin past the pipeline
    localparam int        SINK_HOLD     = 400;
    localparam int        RANDOM_PIXELS = 1200;
    localparam int        DRAIN_LIMIT   = 20000;
    localparam longint    LIMIT_NS      = 1_200_000;
    localparam int        DIM_TOP       = (1 << DIM_W) - 1;
    localparam cfg_idx_t  REG_UNUSED    = 2'd3;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tready  = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_COEF;
    logic [COEFS_W-1:0]     cfg_data  = '0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;
    logic                   cfg_ready;

    int          mismatches;
    int          pending;
    int          results_seen;
    int          frames_seen;
    logic        steady     = 1'b0;
    logic        stall_sink = 1'b0;
    logic        sink_held  = 1'b0;
    int          pixels_sent = 0;
    int          reg_writes  = 0;
    int          resizes     = 0;
    // frame position, so register writes land where intended
    int unsigned cur_w = DIM_RESET;
    int unsigned cur_h = DIM_RESET;
    int unsigned pos_col = 0;
    int unsigned pos_row = 0;

    conv3x3_stream_filter_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    conv3x3_stream_filter_top_check i_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen),
        .frames_seen  (frames_seen)
    );

    initial
    begin
        forever #HALF_PERIOD clk = ~clk;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic int unsigned last_index(input int unsigned d, input int unsigned hi);
        if (d == 0)
            return 2;
        if (d > hi)
            return hi + 1;
        return d + 1;
    endfunction

    function automatic pix_t rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return pix_t'($urandom_range(0, 255));
        endcase
    endfunction

    // dimension in the low bits, junk above that the block must ignore
    function automatic logic [COEFS_W-1:0] dim_word(input int unsigned d);
        logic [63:0]        junk;
        logic [COEFS_W-1:0] w;
        junk = {$urandom(), $urandom()};
        w    = junk[COEFS_W-1:0];
        w[DIM_W-1:0] = d[DIM_W-1:0];
        return w;
    endfunction

    function automatic logic [COEFS_W-1:0] pick_coefs();
        logic [63:0]        r64;
        logic [COEFS_W-1:0] c;
        r64 = {$urandom(), $urandom()};
        c   = r64[COEFS_W-1:0];
        if ($urandom_range(0, 3) == 0)
            for (int i = 0; i < KERNEL * KERNEL; i++)
                case ($urandom_range(0, 2))
                    0:       c[COEF_W*i +: COEF_W] = 7'h40;
                    1:       c[COEF_W*i +: COEF_W] = 7'h3F;
                    default: c[COEF_W*i +: COEF_W] = '0;
                endcase
        return c;
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [COEFS_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == REG_WIDTH)
            cur_w = value[DIM_W-1:0];
        if (idx == REG_HEIGHT)
            cur_h = value[DIM_W-1:0];
        reg_writes++;
    endtask

    task automatic send_pixel(input pix_t p);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pixels_sent++;
        if (pos_col >= last_index(cur_w, MAX_WIDTH_DEF))
        begin
            pos_col = 0;
            pos_row = (pos_row >= last_index(cur_h, MAX_HEIGHT)) ? 0 : pos_row + 1;
        end
        else
            pos_col++;
    endtask

    // random pixels up to the end of the current frame
    task automatic send_frame();
        do
            send_pixel(rand_pixel());
        while (pos_col != 0 || pos_row != 0);
    endtask

    // registers are only touched once the pipeline has emptied
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    // result side: random backpressure, one long hold-off while the input keeps coming
    initial
    begin : sink
        forever
        begin
            @(posedge clk);
            if (stall_sink && !sink_held)
            begin
                m_tready <= 1'b0;
                repeat (SINK_HOLD) @(posedge clk);
                sink_held <= 1'b1;
            end
            m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial
    begin : stimulus
        int unsigned w;
        int unsigned h;
        int unsigned cut;
        int          phase;
        int          base;
        int          waited;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 1x1 output frames via zero dimensions; Sobel default first
        write_reg(REG_WIDTH, dim_word(0));
        write_reg(REG_HEIGHT, dim_word(0));
        for (int i = 0; i < 9; i++)
            send_pixel((i % 3 == 2) ? 8'hFF : 8'h00);
        wait_idle();
        write_reg(REG_COEF, {9{7'h3F}});
        repeat (9) send_pixel(8'hFF);
        wait_idle();
        write_reg(REG_COEF, {9{7'h40}});
        repeat (9) send_pixel(8'hFF);

        base  = pixels_sent;
        phase = 0;
        while (pixels_sent < base + RANDOM_PIXELS)
        begin
            steady <= (phase == 1);
            wait_idle();
            w = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 5);
            write_reg(REG_COEF, pick_coefs());
            write_reg(REG_WIDTH, dim_word(w));
            write_reg(REG_HEIGHT, dim_word(h));
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_UNUSED, pick_coefs());
            if (phase % 4 == 3)
            begin
                // now and then a height above the maximum, which must not close the frame
                if (phase % 8 == 7)
                    write_reg(REG_HEIGHT, dim_word($urandom_range(MAX_HEIGHT + 1, DIM_TOP)));
                // stop inside the frame, shrink it, then let it close early
                cut = $urandom_range(1, (w + 2) * (h + 2) - 1);
                repeat (cut) send_pixel(rand_pixel());
                wait_idle();
                write_reg(REG_COEF, pick_coefs());
                write_reg(REG_WIDTH, dim_word($urandom_range(0, w)));
                write_reg(REG_HEIGHT, dim_word($urandom_range(0, h)));
                resizes++;
                send_frame();
            end
            else
                repeat ($urandom_range(1, 3)) send_frame();
            phase++;
        end

        // long result hold-off while pixels keep coming
        steady <= 1'b0;
        wait_idle();
        write_reg(REG_COEF, pick_coefs());
        write_reg(REG_WIDTH, dim_word($urandom_range(30, 40)));
        write_reg(REG_HEIGHT, dim_word($urandom_range(1, 3)));
        stall_sink <= 1'b1;
        send_frame();

        s_tvalid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_GAP) @(posedge clk);
        if (pending != 0)
            $error("%0d expected result beats never arrived", pending);

        $display("covered %0d pixel beats, %0d result beats, %0d frames, %0d register writes",
                 pixels_sent, results_seen, frames_seen, reg_writes);
        $display("frames from 1x1 up to 40 columns, %0d resized mid-frame, one long stall",
                 resizes);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
